/* src/flsm_pkg.sv */
// shared constants, types and codes for the flash log slot manager
// no dependencies
`timescale 1ns / 1ps
package flsm_pkg;
    localparam int SECTORS           = 8;
    localparam int DESCRIPTORS       = 64;
    localparam int BLOCKS_PER_SECTOR = 128;
    localparam int MIN_BLANKS        = 2;

    localparam int SEC_W   = 3;
    localparam int SLOT_W  = 7;
    localparam int SIDX_W  = $clog2(SECTORS);
    localparam int FP_W    = $clog2(BLOCKS_PER_SECTOR + 1);
    localparam int DIDX_W  = (DESCRIPTORS > 1) ? $clog2(DESCRIPTORS) : 1;
    localparam int DCNT_W  = $clog2(DESCRIPTORS + 1);
    localparam int BLK_W   = $clog2(SECTORS + 1);
    localparam int CMP_W   = (DCNT_W > FP_W) ? DCNT_W : FP_W;

    typedef enum logic [1:0] {
        FN_WRITE = 2'd0,
        FN_READ  = 2'd1,
        FN_VICT  = 2'd2,
        FN_ERASE = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOTFND  = 2'd1,
        ST_ALLFULL = 2'd2,
        ST_NODESC  = 2'd3
    } t_status;

    typedef struct packed {
        logic [15:0]       name;
        logic [7:0]        ext;
        logic [SEC_W-1:0]  sector;
        logic [SLOT_W-1:0] slot;
    } t_desc;
endpackage

/* src/flsm_desc_ram.sv */
// descriptor table memory, one write and one registered read port
// depends on flsm_pkg
`timescale 1ns / 1ps
module flsm_desc_ram (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [flsm_pkg::DIDX_W-1:0] i_waddr,
    input  flsm_pkg::t_desc            i_wdata,
    input  logic                       i_re,
    input  logic [flsm_pkg::DIDX_W-1:0] i_raddr,
    output flsm_pkg::t_desc            o_rdata
);
    import flsm_pkg::*;

    t_desc r_mem [DESCRIPTORS];
    t_desc r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* src/flash_log_slot_manager.sv */
// top level: sequencer, sector fill pointers and descriptor scan
// depends on flsm_pkg and flsm_desc_ram
`timescale 1ns / 1ps
// An item is taken when start is high and busy is low; busy then stays high
// until the single result appears on the o_ ports for one cycle with
// o_valid, which the receiver cannot stall. One shared sequencer walks the
// sectors one per cycle and the descriptor table one entry per cycle through
// its single read port. A write checks up to 8 sectors for one that is not
// full and then scans up to desc_count descriptors; a read scans the
// descriptors; a victim query scans all sectors, and with fewer than MIN_BLANKS
// blank sectors also counts descriptors and picks a victim; an erase clears a fill pointer.
module flash_log_slot_manager (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_func,
    input  logic [15:0]                 i_var_name,
    input  logic [7:0]                  i_var_ext,
    input  logic [2:0]                  i_erase_sector,
    output logic                        o_valid,
    output logic [1:0]                  o_status,
    output logic [flsm_pkg::SEC_W-1:0]  o_sector,
    output logic [flsm_pkg::SLOT_W-1:0] o_slot,
    output logic                        o_replaced,
    output logic [flsm_pkg::SEC_W-1:0]  o_old_sector,
    output logic [flsm_pkg::SLOT_W-1:0] o_old_slot,
    output logic                        o_sector_switched,
    output logic                        o_reloc_needed,
    output logic                        o_victim_found,
    output logic [flsm_pkg::SEC_W-1:0]  o_victim_sector
);
    import flsm_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SWITCH = 7'b0000010,
        S_LOOKUP = 7'b0000100,
        S_VSCAN  = 7'b0001000,
        S_VCNT   = 7'b0010000,
        S_VPICK  = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    t_state              r_state;
    t_func               r_func;
    logic [15:0]         r_name;
    logic [7:0]          r_ext;
    logic [FP_W-1:0]     r_fp [SECTORS];
    logic [SIDX_W-1:0]   r_active;
    logic [DCNT_W-1:0]   r_count;
    logic [SIDX_W-1:0]   r_sidx;
    logic [SIDX_W:0]     r_step;
    logic [DCNT_W-1:0]   r_ridx;
    logic [DIDX_W-1:0]   r_didx;
    logic                r_dv;
    logic [BLK_W-1:0]    r_blanks;
    logic [SECTORS-1:0]  r_full;
    logic [DCNT_W-1:0]   r_cnt [SECTORS];
    logic [CMP_W-1:0]    r_best;

    t_status             r_status;
    logic [SEC_W-1:0]    r_sector;
    logic [SLOT_W-1:0]   r_slot;
    logic                r_repl;
    logic [SEC_W-1:0]    r_osec;
    logic [SLOT_W-1:0]   r_oslot;
    logic                r_switch;
    logic                r_reloc;
    logic                r_vfound;
    logic [SEC_W-1:0]    r_vsec;

    logic [FP_W-1:0]     fp_rd;
    logic                fp_full;
    logic                issue;
    logic                hit;
    logic                ram_we;
    logic [DIDX_W-1:0]   ram_waddr;
    t_desc               ram_wdata;
    t_desc               ram_rdata;
    logic [BLK_W-1:0]    n_blanks;
    logic [SIDX_W-1:0]   sidx_next;
    logic [SIDX_W-1:0]   dsec;

    assign fp_rd     = r_fp[r_sidx];
    assign fp_full   = fp_rd >= FP_W'(BLOCKS_PER_SECTOR);
    assign issue     = (r_ridx < r_count);
    assign hit       = r_dv && (ram_rdata.name == r_name) && (ram_rdata.ext == r_ext);
    assign sidx_next = (r_sidx == SIDX_W'(SECTORS - 1)) ? '0 : r_sidx + 1'b1;
    assign dsec      = ram_rdata.sector[SIDX_W-1:0];

    always_comb begin
        n_blanks = r_blanks;
        if ((r_sidx != r_active) && (fp_rd == '0)) begin
            n_blanks = r_blanks + 1'b1;
        end
    end

    // descriptor update on a write, at the hit or at the next free entry
    always_comb begin
        ram_we          = 1'b0;
        ram_waddr       = r_didx;
        ram_wdata.name   = r_name;
        ram_wdata.ext    = r_ext;
        ram_wdata.sector = SEC_W'(r_sidx);
        ram_wdata.slot   = fp_rd[SLOT_W-1:0];
        if ((r_state == S_LOOKUP) && (r_func == FN_WRITE)) begin
            if (hit) begin
                ram_we = 1'b1;
            end else if (!issue && !r_dv && (r_count < DCNT_W'(DESCRIPTORS))) begin
                ram_we    = 1'b1;
                ram_waddr = r_count[DIDX_W-1:0];
            end
        end
    end

    flsm_desc_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (issue),
        .i_raddr (r_ridx[DIDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_active <= '0;
            r_count  <= '0;
            r_dv     <= 1'b0;
            for (int k = 0; k < SECTORS; k++) begin
                r_fp[k] <= '0;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_func   <= t_func'(i_func);
                        r_name   <= i_var_name;
                        r_ext    <= i_var_ext;
                        r_status <= ST_OK;
                        r_sector <= '0;
                        r_slot   <= '0;
                        r_repl   <= 1'b0;
                        r_osec   <= '0;
                        r_oslot  <= '0;
                        r_switch <= 1'b0;
                        r_reloc  <= 1'b0;
                        r_vfound <= 1'b0;
                        r_vsec   <= '0;
                        r_step   <= '0;
                        r_ridx   <= '0;
                        r_dv     <= 1'b0;
                        r_blanks <= '0;
                        r_full   <= '0;
                        r_best   <= CMP_W'(BLOCKS_PER_SECTOR);
                        for (int k = 0; k < SECTORS; k++) begin
                            r_cnt[k] <= '0;
                        end
                        unique case (t_func'(i_func))
                            FN_WRITE: begin
                                r_sidx  <= r_active;
                                r_state <= S_SWITCH;
                            end
                            FN_READ: r_state <= S_LOOKUP;
                            FN_VICT: begin
                                r_sidx  <= '0;
                                r_state <= S_VSCAN;
                            end
                            FN_ERASE: begin
                                if ({1'b0, i_erase_sector} < 4'(SECTORS)) begin
                                    r_fp[i_erase_sector[SIDX_W-1:0]] <= '0;
                                end
                                r_state <= S_DONE;
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_SWITCH: begin
                    if (!fp_full) begin
                        if (r_sidx != r_active) begin
                            r_active <= r_sidx;
                            r_switch <= 1'b1;
                        end
                        r_state <= S_LOOKUP;
                    end else if (r_step == (SIDX_W + 1)'(SECTORS - 1)) begin
                        r_status <= ST_ALLFULL;
                        r_state  <= S_DONE;
                    end else begin
                        r_sidx <= sidx_next;
                        r_step <= r_step + 1'b1;
                    end
                end
                S_LOOKUP: begin
                    if (issue) begin
                        r_didx <= r_ridx[DIDX_W-1:0];
                        r_ridx <= r_ridx + 1'b1;
                    end
                    r_dv <= issue && !hit;
                    if (hit) begin
                        r_state <= S_DONE;
                        if (r_func == FN_WRITE) begin
                            r_repl   <= 1'b1;
                            r_osec   <= ram_rdata.sector;
                            r_oslot  <= ram_rdata.slot;
                            r_sector <= SEC_W'(r_sidx);
                            r_slot   <= fp_rd[SLOT_W-1:0];
                            r_fp[r_sidx] <= fp_rd + 1'b1;
                        end else begin
                            r_sector <= ram_rdata.sector;
                            r_slot   <= ram_rdata.slot;
                        end
                    end else if (!issue && !r_dv) begin
                        r_state <= S_DONE;
                        if (r_func != FN_WRITE) begin
                            r_status <= ST_NOTFND;
                        end else if (r_count >= DCNT_W'(DESCRIPTORS)) begin
                            r_status <= ST_NODESC;
                        end else begin
                            r_count  <= r_count + 1'b1;
                            r_sector <= SEC_W'(r_sidx);
                            r_slot   <= fp_rd[SLOT_W-1:0];
                            r_fp[r_sidx] <= fp_rd + 1'b1;
                        end
                    end
                end
                S_VSCAN: begin
                    r_blanks <= n_blanks;
                    if ((r_sidx != r_active) && (fp_rd != '0) && fp_full) begin
                        r_full[r_sidx] <= 1'b1;
                    end
                    if (r_sidx == SIDX_W'(SECTORS - 1)) begin
                        r_sidx <= '0;
                        if (n_blanks >= BLK_W'(MIN_BLANKS)) begin
                            r_state <= S_DONE;
                        end else begin
                            r_reloc <= 1'b1;
                            r_state <= S_VCNT;
                        end
                    end else begin
                        r_sidx <= sidx_next;
                    end
                end
                S_VCNT: begin
                    if (issue) begin
                        r_ridx <= r_ridx + 1'b1;
                    end
                    r_dv <= issue;
                    if (r_dv && ({1'b0, ram_rdata.sector} < (SEC_W + 1)'(SECTORS))
                            && r_full[dsec]) begin
                        r_cnt[dsec] <= r_cnt[dsec] + 1'b1;
                    end
                    if (!issue && !r_dv) begin
                        r_state <= S_VPICK;
                    end
                end
                S_VPICK: begin
                    if (r_full[r_sidx] && (CMP_W'(r_cnt[r_sidx]) < r_best)) begin
                        r_best   <= CMP_W'(r_cnt[r_sidx]);
                        r_vfound <= 1'b1;
                        r_vsec   <= SEC_W'(r_sidx);
                    end
                    if (r_sidx == SIDX_W'(SECTORS - 1)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_sidx <= sidx_next;
                    end
                end
                S_DONE: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy              = (r_state != S_IDLE);
    assign o_valid           = (r_state == S_DONE);
    assign o_status          = r_status;
    assign o_sector          = r_sector;
    assign o_slot            = r_slot;
    assign o_replaced        = r_repl;
    assign o_old_sector      = r_osec;
    assign o_old_slot        = r_oslot;
    assign o_sector_switched = r_switch;
    assign o_reloc_needed    = r_reloc;
    assign o_victim_found    = r_vfound;
    assign o_victim_sector   = r_vsec;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DCNT_W'(DESCRIPTORS))
        else $error("descriptor count beyond table");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !busy)
        else $error("busy after result");
    a_repl_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_replaced) |-> (o_status == ST_OK))
        else $error("replaced copy with error status");
    a_victim_reloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_victim_found) |-> o_reloc_needed)
        else $error("victim without relocation need");
endmodule
